[rtl/core/gregorian_date_offset_top_macros.svh]
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of i_clk and is quiet while i_rst_n is low.
`ifndef GREGORIAN_DATE_OFFSET_TOP_MACROS_SVH
`define GREGORIAN_DATE_OFFSET_TOP_MACROS_SVH

// Same-cycle implication
`define GDO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define GDO_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/gdo_pkg.sv]
package gdo_pkg;

    // Field widths
    localparam int YEAR_W     = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int OFS_W      = 17;
    localparam int STAT_W     = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;
    localparam int DAY_ACC_W  = 18;

    // Defaults and limits
    localparam int YEAR_MAX_DEF = 9999;
    localparam int MAX_OFFSET   = 65535;
    // Saturation point for the offset magnitude (magnitude never exceeds MAX_OFFSET, 65535)
    localparam logic [OFS_W-1:0] MAG_SAT =
        (MAX_OFFSET >= 65536) ? OFS_W'(65536) : OFS_W'(MAX_OFFSET);

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_START  = 2'd1,
        ST_YEAR_RANGE = 2'd2
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic init;
        logic step;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic walk_done;
        logic out_free;
    } t_dp_sts;

    // Month lengths, common year then leap year
    localparam logic [DAY_W-1:0] MONTH_LEN [0:1][0:11] = '{
        '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31},
        '{5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31}
    };

    // Leap rule from year mod 100 and (year / 100) mod 4
    function automatic logic f_leap(input logic [6:0] ymod, input logic [1:0] cent);
        logic res;
        if (ymod == 7'd0) begin
            res = (cent == 2'd0);
        end else begin
            res = (ymod[1:0] == 2'd0);
        end
        return res;
    endfunction

    // Length of month m (1..12); zero for a month code that means nothing
    function automatic logic [DAY_W-1:0] f_days_in(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [MONTH_W-1:0] idx;
        logic [DAY_W-1:0]   res;
        idx = m - 4'd1;
        if (idx < 4'd12) begin
            res = MONTH_LEN[leap][idx];
        end else begin
            res = '0;
        end
        return res;
    endfunction

endpackage

[rtl/core/gdo_ctrl.sv]
module gdo_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output gdo_pkg::t_dp_cmd o_cmd,
    input  gdo_pkg::t_dp_sts i_sts
);
    import gdo_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_WALK,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_WALK;
            end
            S_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/gdo_dp.sv]
module gdo_dp #(
    parameter int YEAR_MAX = gdo_pkg::YEAR_MAX_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gdo_pkg::t_dp_cmd                   i_cmd,
    output gdo_pkg::t_dp_sts                   o_sts,
    input  logic [gdo_pkg::IN_DATA_W-1:0]      i_in_data,
    input  logic                               i_in_func,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [gdo_pkg::OUT_DATA_W-1:0]     o_out_data,
    output logic [gdo_pkg::STAT_W-1:0]         o_out_status
);
    import gdo_pkg::*;

    // Walk year width covers both the input field and the year limit
    localparam int YR_W = ($clog2(YEAR_MAX + 1) > YEAR_W) ? $clog2(YEAR_MAX + 1) : YEAR_W;
    localparam logic [YR_W-1:0] YMAX = YR_W'(YEAR_MAX);

    // Start beat
    logic                    r_func;
    logic [YEAR_W-1:0]       r_start_year;
    logic [MONTH_W-1:0]      r_start_month;
    logic [DAY_W-1:0]        r_start_day;
    logic [OFS_W-1:0]        r_raw;
    logic [7:0]              r_quot;

    // Walk state
    logic [YR_W-1:0]         r_year;
    logic [MONTH_W-1:0]      r_month;
    logic signed [DAY_ACC_W-1:0] r_d;
    logic                    r_fwd;
    logic [6:0]              r_ymod;
    logic [1:0]              r_cent;
    t_status                 r_status;

    // Output register
    logic                    r_out_valid;
    logic [YEAR_W-1:0]       r_out_year;
    logic [MONTH_W-1:0]      r_out_month;
    logic [DAY_W-1:0]        r_out_day;
    t_status                 r_out_status;

    // year / 100 by reciprocal, exact for any 14-bit year
    logic [26:0] w_prod;
    logic [7:0]  w_quot;
    assign w_prod = 27'(i_in_data[YEAR_W-1:0]) * 27'(5243);
    assign w_quot = w_prod[26:19];

    // Setup: year mod 100, start validity, magnitude and direction
    logic [YEAR_W-1:0]       w_q100;
    logic [YEAR_W-1:0]       w_rem;
    logic [6:0]              w_ymod0;
    logic                    w_leap0;
    logic                    w_bad;
    logic [OFS_W-1:0]        w_mag_raw;
    logic [OFS_W-1:0]        w_mag;
    logic                    w_fwd0;
    logic signed [DAY_ACC_W-1:0] w_d0;

    assign w_q100    = YEAR_W'(r_quot) * YEAR_W'(100);
    assign w_rem     = r_start_year - w_q100;
    assign w_ymod0   = w_rem[6:0];
    assign w_leap0   = f_leap(w_ymod0, r_quot[1:0]);
    assign w_bad     = (YR_W'(r_start_year) > YMAX) || (r_start_month < 4'd1) ||
                       (r_start_month > 4'd12) || (r_start_day < 5'd1) ||
                       (r_start_day > f_days_in(r_start_month, w_leap0));
    assign w_mag_raw = r_raw[OFS_W-1] ? (OFS_W'(0) - r_raw) : r_raw;
    assign w_mag     = (w_mag_raw > MAG_SAT) ? MAG_SAT : w_mag_raw;
    assign w_fwd0    = (r_func == 1'b0) != r_raw[OFS_W-1];
    assign w_d0      = w_fwd0 ?
                       ($signed(DAY_ACC_W'(r_start_day)) + $signed(DAY_ACC_W'(w_mag))) :
                       ($signed(DAY_ACC_W'(r_start_day)) - $signed(DAY_ACC_W'(w_mag)));

    // Walk step: one month per cycle
    logic                    w_leap;
    logic [DAY_W-1:0]        w_dim;
    logic [DAY_W-1:0]        w_prev_dim;
    logic                    w_more;
    assign w_leap     = f_leap(r_ymod, r_cent);
    assign w_dim      = f_days_in(r_month, w_leap);
    assign w_prev_dim = f_days_in(r_month - 4'd1, w_leap);
    assign w_more     = r_fwd ? (r_d > $signed(DAY_ACC_W'(w_dim))) :
                                (r_d < $signed(DAY_ACC_W'(1)));

    assign o_sts.walk_done = (r_status != ST_OK) || !w_more;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func        <= i_in_func;
            r_start_year  <= i_in_data[13:0];
            r_start_month <= i_in_data[17:14];
            r_start_day   <= i_in_data[22:18];
            r_raw         <= i_in_data[39:23];
            r_quot        <= w_quot;
        end
        if (i_cmd.init) begin
            r_year   <= YR_W'(r_start_year);
            r_month  <= r_start_month;
            r_ymod   <= w_ymod0;
            r_cent   <= r_quot[1:0];
            r_fwd    <= w_fwd0;
            r_d      <= w_d0;
            r_status <= w_bad ? ST_BAD_START : ST_OK;
        end else if (i_cmd.step) begin
            if (r_fwd) begin
                if (r_month == 4'd12) begin
                    if (r_year >= YMAX) begin
                        r_status <= ST_YEAR_RANGE;
                    end else begin
                        r_d     <= r_d - $signed(DAY_ACC_W'(w_dim));
                        r_year  <= r_year + YR_W'(1);
                        r_month <= 4'd1;
                        r_ymod  <= (r_ymod == 7'd99) ? 7'd0 : r_ymod + 7'd1;
                        r_cent  <= (r_ymod == 7'd99) ? r_cent + 2'd1 : r_cent;
                    end
                end else begin
                    r_d     <= r_d - $signed(DAY_ACC_W'(w_dim));
                    r_month <= r_month + 4'd1;
                end
            end else begin
                if (r_month == 4'd1) begin
                    if (r_year == '0) begin
                        r_status <= ST_YEAR_RANGE;
                    end else begin
                        // December is 31 days in every year
                        r_d     <= r_d + $signed(DAY_ACC_W'(31));
                        r_year  <= r_year - YR_W'(1);
                        r_month <= 4'd12;
                        r_ymod  <= (r_ymod == 7'd0) ? 7'd99 : r_ymod - 7'd1;
                        r_cent  <= (r_ymod == 7'd0) ? r_cent - 2'd1 : r_cent;
                    end
                end else begin
                    r_d     <= r_d + $signed(DAY_ACC_W'(w_prev_dim));
                    r_month <= r_month - 4'd1;
                end
            end
        end
    end

    // Output payload; an error echoes the start date
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            if (r_status == ST_OK) begin
                r_out_year  <= r_year[YEAR_W-1:0];
                r_out_month <= r_month;
                r_out_day   <= r_d[DAY_W-1:0];
            end else begin
                r_out_year  <= r_start_year;
                r_out_month <= r_start_month;
                r_out_day   <= r_start_day;
            end
        end
    end

    // Output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = {1'b0, r_out_day, r_out_month, r_out_year};
    assign o_out_status = r_out_status;

endmodule

[rtl/core/gregorian_date_offset_top.sv]
// One request is worked on at a time; the month walk advances one month per cycle
// through days-in-month lookups and a single day accumulator.
// The next input beat is taken while a finished result waits in the output register.
// Reset: synchronous, active low; clears the controller state and output valid.
module gregorian_date_offset_top #(
    parameter int YEAR_MAX = gdo_pkg::YEAR_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [13:0] start_year, [17:14] start_month, [22:18] start_day, [39:23] offset_days
    input  logic [gdo_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] func
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [13:0] result_year, [17:14] result_month, [22:18] result_day, [23] zero
    output logic [gdo_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [1:0] status
    output logic [gdo_pkg::STAT_W-1:0]      m_axis_tuser
);
    import gdo_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    gdo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    gdo_dp #(
        .YEAR_MAX (YEAR_MAX)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_in_data    (s_axis_tdata),
        .i_in_func    (s_axis_tuser),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata),
        .o_out_status (m_axis_tuser)
    );

endmodule

[rtl/core/gdo_chk.sv]
`include "gregorian_date_offset_top_macros.svh"

module gdo_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [gdo_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [gdo_pkg::STAT_W-1:0]      m_axis_tuser
);
    import gdo_pkg::*;

    logic w_in_beat;
    assign w_in_beat = s_axis_tvalid && s_axis_tready;

    // One item in flight: no new input beat right after one is taken
    `GDO_ASSERT_NXT(a_one_in_flight, w_in_beat, !s_axis_tready, "input taken while busy")

    // A result never appears on the cycle right after its input beat
    `GDO_ASSERT_NXT(a_min_latency, w_in_beat, !$rose(m_axis_tvalid), "result too early")

    // A good result carries a month of 1..12, a nonzero day and a zero pad bit
    `GDO_ASSERT_IMP(a_ok_date, m_axis_tvalid && (m_axis_tuser == ST_OK),
        (m_axis_tdata[17:14] >= 4'd1) && (m_axis_tdata[17:14] <= 4'd12) &&
        (m_axis_tdata[22:18] >= 5'd1) && (m_axis_tdata[23] == 1'b0), "bad result date")

    // Stalled output beat holds
    `GDO_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat dropped")

endmodule

bind gregorian_date_offset_top gdo_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/sv/tb_gregorian_date_offset_top.sv]
module tb_gregorian_date_offset_top;
    import gdo_pkg::*;

    // Field positions in the output beat
    localparam int MON_LO = YEAR_W;
    localparam int DAY_LO = YEAR_W + MONTH_W;
    localparam int PAD_LO = YEAR_W + MONTH_W + DAY_W;

    typedef struct {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        t_status            status;
    } t_date_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [13:0] start_year, [17:14] start_month, [22:18] start_day, [39:23] offset_days
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    // [0] func
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [13:0] result_year, [17:14] result_month, [22:18] result_day, [23] zero
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    // [1:0] status
    logic [STAT_W-1:0]      m_axis_tuser;

    t_date_result pending_dates[$];
    int           mismatch_count = 0;
    bit           no_idle = 1'b0;
    int           hold_request = 0;

    gregorian_date_offset_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Days in month m of year y, Gregorian leap rule, year 0 is leap
    function automatic int month_days(input int y, input int m);
        int leap;
        leap = ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 1 : 0;
        case (m)
            2:              return 28 + leap;
            4, 6, 9, 11:    return 30;
            default:        return 31;
        endcase
    endfunction

    // Expected result: walk month by month from the start date
    function automatic t_date_result predict_offset_date(input logic func,
                                                         input logic [YEAR_W-1:0] sy,
                                                         input logic [MONTH_W-1:0] sm,
                                                         input logic [DAY_W-1:0] sd,
                                                         input logic [OFS_W-1:0] raw);
        t_date_result r;
        int  mag;
        int  y;
        int  m;
        int  d;
        bit  fwd;
        r.year   = sy;
        r.month  = sm;
        r.day    = sd;
        r.status = ST_OK;
        mag = raw[OFS_W-1] ? (32'h20000 - int'({15'b0, raw})) : int'({15'b0, raw});
        if (mag > MAX_OFFSET)
            mag = MAX_OFFSET;
        fwd = (func == 1'b0) != raw[OFS_W-1];
        y = int'(sy);
        m = int'(sm);
        d = 0;
        if (y > YEAR_MAX_DEF || m < 1 || m > 12 || sd == 0 || int'(sd) > month_days(y, m)) begin
            r.status = ST_BAD_START;
        end else if (fwd) begin
            d = int'(sd) + mag;
            while (r.status == ST_OK && d > month_days(y, m)) begin
                if (m == 12 && y >= YEAR_MAX_DEF) begin
                    r.status = ST_YEAR_RANGE;
                end else begin
                    d -= month_days(y, m);
                    if (m == 12) begin
                        y++;
                        m = 1;
                    end else begin
                        m++;
                    end
                end
            end
        end else begin
            d = int'(sd) - mag;
            while (r.status == ST_OK && d < 1) begin
                if (m == 1 && y == 0) begin
                    r.status = ST_YEAR_RANGE;
                end else begin
                    if (m == 1) begin
                        y--;
                        m = 12;
                    end else begin
                        m--;
                    end
                    d += month_days(y, m);
                end
            end
        end
        if (r.status == ST_OK) begin
            r.year  = YEAR_W'(y);
            r.month = MONTH_W'(m);
            r.day   = DAY_W'(d);
        end
        return r;
    endfunction

    // Send one request beat; called and returns at a falling edge
    task automatic send_date(input logic func, input int y, input int m, input int d,
                             input int ofs);
        t_date_result     want;
        logic [OFS_W-1:0] raw;
        raw  = OFS_W'(ofs);
        want = predict_offset_date(func, YEAR_W'(y), MONTH_W'(m), DAY_W'(d), raw);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 25) begin
                s_axis_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
        s_axis_tuser  = func;
        s_axis_tdata  = {raw, DAY_W'(d), MONTH_W'(m), YEAR_W'(y)};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pending_dates.push_back(want);
        @(negedge i_clk);
    endtask

    // Mostly valid dates with small offsets, some large, some raw noise
    task automatic send_random_date();
        int   pick;
        int   y;
        int   m;
        int   d;
        int   mag;
        int   ofs;
        logic func;
        func = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            y   = $urandom_range(0, 16383);
            m   = $urandom_range(0, 15);
            d   = $urandom_range(0, 31);
            ofs = $urandom_range(0, 131071);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                y = $urandom_range(0, 3);
            else if (pick < 20)
                y = $urandom_range(9996, 9999);
            else
                y = $urandom_range(0, 9999);
            m    = $urandom_range(1, 12);
            d    = $urandom_range(1, month_days(y, m));
            pick = $urandom_range(0, 99);
            if (pick < 60)
                mag = $urandom_range(0, 400);
            else if (pick < 88)
                mag = $urandom_range(0, 20000);
            else
                mag = $urandom_range(0, 65536);
            ofs = $urandom_range(0, 1) ? -mag : mag;
        end
        send_date(func, y, m, d, ofs);
    endtask

    // Leap years: plain, century, 400-year century, year 0
    task automatic test_leap_rule();
        send_date(1'b0, 2024, 2, 28, 1);
        send_date(1'b0, 2023, 2, 28, 1);
        send_date(1'b0, 1900, 2, 28, 1);
        send_date(1'b0, 2000, 2, 28, 1);
        send_date(1'b1, 0, 3, 1, 1);
    endtask

    // Walks that run off either end of the year range, both directions, and a zero offset
    task automatic test_year_limits();
        send_date(1'b0, 9999, 12, 31, 1);
        send_date(1'b1, 0, 1, 1, 1);
        send_date(1'b0, 0, 1, 1, -1);
        send_date(1'b1, 9999, 12, 31, -1);
        send_date(1'b0, 9999, 12, 31, 0);
    endtask

    // Zero offset, largest offset, saturated -65536, both funcs
    task automatic test_offset_extremes();
        send_date(1'b0, 2020, 6, 15, 0);
        send_date(1'b1, 2020, 6, 15, 0);
        send_date(1'b0, 5000, 7, 4, 65535);
        send_date(1'b1, 5000, 7, 4, 65535);
        send_date(1'b0, 5000, 7, 4, -65536);
        send_date(1'b1, 5000, 7, 4, -65536);
        send_date(1'b0, 0, 1, 1, 65535);
        send_date(1'b1, 9999, 12, 31, 65535);
    endtask

    // Start dates that must be rejected and echoed
    task automatic test_bad_start_dates();
        send_date(1'b0, 10000, 1, 1, 5);
        send_date(1'b1, 16383, 15, 31, -1);
        send_date(1'b0, 2020, 0, 10, 5);
        send_date(1'b0, 2020, 13, 10, 5);
        send_date(1'b1, 2020, 5, 0, 5);
        send_date(1'b0, 2021, 4, 31, 5);
        send_date(1'b0, 2023, 2, 29, 5);
        send_date(1'b1, 1900, 2, 29, 5);
    endtask

    task automatic test_random_walks(input int count);
        repeat (count)
            send_random_date();
    endtask

    // No gaps on either side
    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        repeat (count)
            send_random_date();
        no_idle = 1'b0;
    endtask

    // Receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_stall(input int count);
        hold_request = 400;
        repeat (count)
            send_date(1'($urandom_range(0, 1)), $urandom_range(1, 9998),
                      $urandom_range(1, 12), $urandom_range(1, 28), $urandom_range(0, 200));
    endtask

    // Receiver side: random stalls, calm stretches, long holds on request
    initial begin : drive_ready
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else if (no_idle) begin
                m_axis_tready = 1'b1;
            end else begin
                m_axis_tready = ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // Compare each result beat with the oldest expected date
    always @(posedge i_clk) begin : check_results
        t_date_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_dates.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result beat data=%h status=%0d", $time,
                         m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_dates.pop_front();
                if (m_axis_tdata[MON_LO-1:0] !== want.year ||
                    m_axis_tdata[DAY_LO-1:MON_LO] !== want.month ||
                    m_axis_tdata[PAD_LO-1:DAY_LO] !== want.day ||
                    m_axis_tdata[OUT_DATA_W-1:PAD_LO] !== '0 ||
                    m_axis_tuser !== want.status) begin
                    mismatch_count++;
                    $display("%0t: expected %0d-%0d-%0d st %0d, got %0d-%0d-%0d st %0d pad %b",
                             $time, want.year, want.month, want.day, want.status,
                             m_axis_tdata[MON_LO-1:0], m_axis_tdata[DAY_LO-1:MON_LO],
                             m_axis_tdata[PAD_LO-1:DAY_LO], m_axis_tuser,
                             m_axis_tdata[OUT_DATA_W-1:PAD_LO]);
                end
            end
        end
    end

    // Main sequence
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_leap_rule();
        test_year_limits();
        test_offset_extremes();
        test_bad_start_dates();
        test_random_walks(200);
        test_back_to_back(40);
        test_output_stall(10);

        // Drain, then watch for stray beats for about one worst-case latency
        s_axis_tvalid = 1'b0;
        while (pending_dates.size() != 0)
            @(posedge i_clk);
        repeat (2200) @(posedge i_clk);

        if (mismatch_count == 0 && pending_dates.size() == 0)
            $display("** gregorian_date_offset_top: PASSED **");
        else
            $display("** gregorian_date_offset_top: FAILED **");
        $finish;
    end

    // Watchdog
    initial begin
        #60_000_000;
        $display("** gregorian_date_offset_top: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/gdo_pkg.sv
rtl/core/gdo_ctrl.sv
rtl/core/gdo_dp.sv
rtl/core/gregorian_date_offset_top.sv
rtl/core/gdo_chk.sv
tb/sv/tb_gregorian_date_offset_top.sv
